>>> hw/rtl/pilot_framed_command_receiver_core_assert.svh
// ---------------------------------------------------------------------------
// pilot framed command receiver assertion macros
// concurrent checks, compiled away for synthesis
// ---------------------------------------------------------------------------
`ifndef PILOT_FRAMED_COMMAND_RECEIVER_CORE_ASSERT_SVH
`define PILOT_FRAMED_COMMAND_RECEIVER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define PFCR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define PFCR_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`else

`define PFCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFCR_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)

`endif

`endif

>>> hw/rtl/pfcr_pkg.sv
// ---------------------------------------------------------------------------
// pfcr_pkg
// types and constants shared by the pilot framed command receiver
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfcr_pkg;

    // default pilot length in bytes
    localparam int PILOT_LEN_DEF = 4;

    // pilot byte pattern, even and odd positions
    localparam logic [7:0] PILOT_EVEN = 8'hAA;
    localparam logic [7:0] PILOT_ODD  = 8'h55;

    // timeout register value after reset
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // request type codes
    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_type_t;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    // input item
    typedef struct packed {
        req_type_t  req_type;
        logic [7:0] rx_byte;
    } req_t;

    // result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_index;
        logic [7:0] byte_value;
        logic [7:0] frame_length;
    } res_t;

    // configuration write
    typedef struct packed {
        logic [15:0] timeout_ms;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/pfcr_stream_if.sv
// ---------------------------------------------------------------------------
// pfcr_stream_if
// valid/ready channel carrying one payload struct per transfer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pfcr_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

>>> hw/rtl/pilot_framed_command_receiver_core.sv
// ---------------------------------------------------------------------------
// pilot_framed_command_receiver_core
// hunts framed commands in a byte stream, reports payload bytes and completion
// ---------------------------------------------------------------------------
//
//  channel  direction  payload                                       role
//  req      in         req_type, rx_byte                             byte or ms tick
//  res      out        kind, data_index, byte_value, frame_length    result
//  cfg      in         timeout_ms                                    timeout write
//
//  one item per cycle while res is not stalled; each item waits in the input
//  register and its result, if any, lands in the result register on the edge
//  at which the item steps into the decoder; res valid rises once the result
//  register is loaded, so the input and result registers lie between req and res
//  a stalled res holds the result register, which in turn holds the input
//  register, so req ready drops only while both are full
//  rst_n clears the frame position, timer and timeout register (1000 ms)
//  cfg is always ready
//
`timescale 1ns / 1ps
`default_nettype none

module pilot_framed_command_receiver_core #(
    parameter int PILOT_LEN = pfcr_pkg::PILOT_LEN_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pfcr_stream_if.sink   req,
    pfcr_stream_if.source res,
    pfcr_stream_if.sink   cfg
);
    import pfcr_pkg::*;

    logic        free;
    logic        item_valid;
    logic        step;
    req_t        item;
    logic        dec_valid;
    res_t        dec_res;
    logic [15:0] timeout_ms_reg;

    // timeout register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ms_reg <= TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            timeout_ms_reg <= cfg.data.timeout_ms;
        end
    end

    // item moves to the decoder when the result slot can take it
    assign step = item_valid && free;

    // input register
    pfcr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .down_free  (free),
        .item       (item),
        .item_valid (item_valid)
    );

    // frame decoder
    pfcr_decoder #(
        .PILOT_LEN (PILOT_LEN)
    ) u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (item),
        .timeout_ms (timeout_ms_reg),
        .res_valid  (dec_valid),
        .res        (dec_res)
    );

    // result register
    pfcr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (dec_valid),
        .res_in    (dec_res),
        .free      (free),
        .res       (res)
    );

endmodule

`default_nettype wire

>>> hw/rtl/pfcr_in_reg.sv
// ---------------------------------------------------------------------------
// pfcr_in_reg
// input register stage, holds one accepted request until the decoder takes it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfcr_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    pfcr_stream_if.sink        req,
    input  wire logic          down_free,
    output pfcr_pkg::req_t     item,
    output logic               item_valid
);
    import pfcr_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t item_reg;
    logic take;

    // accept when empty or when the held item moves on this cycle
    assign req.ready = !valid_reg || down_free;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (down_free)
        begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= req.data;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pfcr_decoder.sv
// ---------------------------------------------------------------------------
// pfcr_decoder
// frame position counter, length and timeout state, one item per cycle while step is high
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pilot_framed_command_receiver_core_assert.svh"

module pfcr_decoder #(
    parameter int PILOT_LEN = pfcr_pkg::PILOT_LEN_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire pfcr_pkg::req_t item,
    input  wire logic [15:0]    timeout_ms,
    output logic                res_valid,
    output pfcr_pkg::res_t      res
);
    import pfcr_pkg::*;

    localparam int POS_W = $clog2(PILOT_LEN + 257);
    localparam logic [POS_W-1:0] PILOT_POS = POS_W'(PILOT_LEN);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       len_reg;
    logic [7:0]       len_next;
    logic [15:0]      left_reg;
    logic [15:0]      left_next;
    logic             running_reg;
    logic             running_next;

    logic [POS_W-1:0] k;
    logic [POS_W-1:0] len_ext;
    logic [15:0]      left_dec;
    logic [7:0]       want;

    // derived values
    assign k        = pos_reg - PILOT_POS;
    assign len_ext  = POS_W'(len_reg);
    assign left_dec = (left_reg != 16'd0) ? (left_reg - 16'd1) : left_reg;
    assign want     = pos_reg[0] ? PILOT_ODD : PILOT_EVEN;

    // next state and result
    always_comb
    begin
        pos_next         = pos_reg;
        len_next         = len_reg;
        left_next        = left_reg;
        running_next     = running_reg;
        res_valid        = 1'b0;
        res.kind         = KIND_DATA;
        res.data_index   = 8'd0;
        res.byte_value   = 8'd0;
        res.frame_length = len_reg;
        if (step)
        begin
            if (item.req_type == REQ_TICK)
            begin
                if (running_reg)
                begin
                    left_next = left_dec;
                    if (left_dec == 16'd0)
                    begin
                        running_next = 1'b0;
                        if (pos_reg != '0)
                        begin
                            pos_next  = '0;
                            res_valid = 1'b1;
                            res.kind  = KIND_ABORT;
                        end
                    end
                end
            end
            else if (pos_reg < PILOT_POS)
            begin
                // pilot hunt, a mismatch restarts without recheck
                pos_next = (item.rx_byte == want) ? (pos_reg + 1'b1) : '0;
            end
            else if (pos_reg == PILOT_POS)
            begin
                // length byte arms the timeout
                len_next     = item.rx_byte;
                left_next    = timeout_ms;
                running_next = 1'b1;
                pos_next     = pos_reg + 1'b1;
            end
            else if (k <= len_ext)
            begin
                // payload byte
                pos_next       = pos_reg + 1'b1;
                res_valid      = 1'b1;
                res.kind       = KIND_DATA;
                res.data_index = 8'(k - 1'b1);
                res.byte_value = item.rx_byte;
            end
            else if (k == len_ext + 1'b1)
            begin
                // command byte closes the frame
                pos_next       = '0;
                running_next   = 1'b0;
                res_valid      = 1'b1;
                res.kind       = KIND_DONE;
                res.byte_value = item.rx_byte;
            end
            else
            begin
                pos_next = '0;
            end
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            len_reg     <= 8'd0;
            left_reg    <= 16'd0;
            running_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            left_reg    <= left_next;
            running_reg <= running_next;
        end
    end

    // checks
    `PFCR_ASSERT(a_run_past_len, clk, rst_n, !running_reg || (pos_reg > PILOT_POS), "timer armed outside payload")
    `PFCR_ASSERT(a_abort_armed, clk, rst_n, !(res_valid && res.kind == KIND_ABORT) || running_reg, "abort with timer stopped")
    `PFCR_ASSERT_NEXT(a_done_restart, clk, rst_n, res_valid && res.kind == KIND_DONE, pos_reg == '0 && !running_reg, "no restart after command byte")
    `PFCR_ASSERT(a_pos_range, clk, rst_n, pos_reg <= PILOT_POS + POS_W'(256), "frame position out of range")

endmodule

`default_nettype wire

>>> hw/rtl/pfcr_out_reg.sv
// ---------------------------------------------------------------------------
// pfcr_out_reg
// result register, holds one result until the sink takes it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfcr_out_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic           res_valid,
    input  wire pfcr_pkg::res_t res_in,
    output logic                free,
    pfcr_stream_if.source       res
);
    import pfcr_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    // free when empty or emptied by a transfer this cycle
    assign free = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = step && res_valid;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (free && step && res_valid)
        begin
            data_reg <= res_in;
        end
    end

    assign res.valid = valid_reg;
    assign res.data  = data_reg;

endmodule

`default_nettype wire
